@@ rtl/tadc_pkg.sv @@
`default_nettype none

package tadc_pkg;

   // converter and register widths
   localparam int ADC_BITS = 10;
   localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
   localparam int RS_W = 20;
   localparam int COEF_W = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // register reset values
   localparam logic [RS_W-1:0] RS_RESET = 20'd10000;
   localparam logic [COEF_W-1:0] A0_RESET = 48'd69591178000;
   localparam logic [COEF_W-1:0] A1_RESET = 48'd65871480550;
   localparam logic [COEF_W-1:0] A3_RESET = 48'd39068074;

   // log2 unit: mantissa in q1.31, fraction in q.30
   localparam int M_W = 32;
   localparam int N_W = 5;
   localparam int FRAC_BITS = 30;
   localparam int LOG_ROUNDS = FRAC_BITS;
   localparam int LOG_W = N_W + FRAC_BITS;
   localparam int MAG_W = LOG_W + 1;

   // natural log scaling
   localparam logic [27:0] LN2_Q28 = 28'd186065279;
   localparam int LN2_SH = 28;
   localparam int LMAG_W = MAG_W;
   localparam int LSQ_W = 2 * LMAG_W - FRAC_BITS;
   localparam int LCUB_W = LSQ_W + LMAG_W - FRAC_BITS;
   localparam int SUM_W = 64;

   // split multiplier: 48 x 48 from four 24 x 24 partials
   localparam int LIMB_W = 24;
   localparam int MUL_W = 2 * LIMB_W;
   localparam int PROD_W = 2 * MUL_W;

   // divider and output
   localparam int Q_W = 16;
   localparam int DIV_W = SUM_W + Q_W;
   localparam logic [SUM_W-1:0] K_NUM = 64'd100 << 48;
   localparam logic [Q_W-1:0] K_MAX = 16'd60082;
   localparam logic [Q_W:0] KELVIN_CENTI = 17'd27315;
   localparam logic [15:0] TEMP_MAX = 16'd32767;

   // pipeline stage numbering; the first divider step shares the D1 slot
   localparam int ST_C1 = LOG_ROUNDS + 1;
   localparam int ST_M0 = ST_C1 + 1;
   localparam int ST_M1 = ST_M0 + 1;
   localparam int ST_Q0 = ST_M1 + 1;
   localparam int ST_Q1 = ST_Q0 + 1;
   localparam int ST_R0 = ST_Q1 + 1;
   localparam int ST_R1 = ST_R0 + 1;
   localparam int ST_T0 = ST_R1 + 1;
   localparam int ST_T1 = ST_T0 + 1;
   localparam int ST_U1 = ST_T1 + 1;
   localparam int ST_U2 = ST_U1 + 1;
   localparam int ST_D0 = ST_U2 + 1;
   localparam int ST_D1 = ST_D0 + 1;
   localparam int N_STAGES = ST_D1 + Q_W;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OPEN  = 2'd1,
      STAT_SHORT = 2'd2,
      STAT_SAT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_SERIES_RES = 2'd0,
      REG_COEF_A0    = 2'd1,
      REG_COEF_A1    = 2'd2,
      REG_COEF_A3    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [N_W-1:0] n;
      logic [M_W-1:0] m;
      logic [FRAC_BITS-1:0] frac;
   } log_type;

   typedef struct packed {
      log_type r;
      log_type c;
      log_type f;
   } log_stage_type;

   typedef struct packed {
      logic valid;
      status_type pre;
      logic neg;
      logic sat;
   } ctl_type;

   typedef struct packed {
      logic [MUL_W-1:0] p00;
      logic [MUL_W-1:0] p01;
      logic [MUL_W-1:0] p10;
      logic [MUL_W-1:0] p11;
   } pp_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] s;
      logic [Q_W-1:0] q;
   } div_type;

   // top set bit and left-justified mantissa
   function automatic log_type log_norm(logic [M_W-1:0] x);
      log_type r;
      logic [N_W-1:0] n;
      n = '0;
      for (int i = 0; i < M_W; i++) begin
         if (x[i]) n = N_W'(i);
      end
      r.n = n;
      r.m = x << (N_W'(M_W - 1) - n);
      r.frac = '0;
      return r;
   endfunction

   // one squaring round, one fraction bit
   function automatic log_type log_round(log_type a);
      log_type r;
      logic [2*M_W-1:0] p;
      p = {{M_W{1'b0}}, a.m} * {{M_W{1'b0}}, a.m};
      r.n = a.n;
      r.frac = {a.frac[FRAC_BITS-2:0], p[2*M_W-1]};
      r.m = p[2*M_W-1] ? p[2*M_W-1:M_W] : p[2*M_W-2:M_W-1];
      return r;
   endfunction

   // partial products of two 48-bit operands
   function automatic pp_type pp_mul(logic [MUL_W-1:0] a, logic [MUL_W-1:0] b);
      pp_type r;
      r.p00 = {{LIMB_W{1'b0}}, a[LIMB_W-1:0]} * {{LIMB_W{1'b0}}, b[LIMB_W-1:0]};
      r.p01 = {{LIMB_W{1'b0}}, a[LIMB_W-1:0]} * {{LIMB_W{1'b0}}, b[MUL_W-1:LIMB_W]};
      r.p10 = {{LIMB_W{1'b0}}, a[MUL_W-1:LIMB_W]} * {{LIMB_W{1'b0}}, b[LIMB_W-1:0]};
      r.p11 = {{LIMB_W{1'b0}}, a[MUL_W-1:LIMB_W]} * {{LIMB_W{1'b0}}, b[MUL_W-1:LIMB_W]};
      return r;
   endfunction

   function automatic logic [PROD_W-1:0] pp_sum(pp_type p);
      return {{MUL_W{1'b0}}, p.p00}
           + ({{MUL_W{1'b0}}, p.p01} << LIMB_W)
           + ({{MUL_W{1'b0}}, p.p10} << LIMB_W)
           + ({{MUL_W{1'b0}}, p.p11} << MUL_W);
   endfunction

endpackage

`default_nettype wire

@@ rtl/thermistor_adc_to_celsius_top.sv @@
`default_nettype none

// channel   direction  handshake                  payload
// req_      in         req_valid / req_stall      req_adc_code
// rsp_      out        rsp_valid / rsp_stall      rsp_temp_centi_c, rsp_status
// csr_      in/out     csr_psel / csr_penable     csr_paddr, csr_pwdata, csr_prdata
//
// one word is taken every cycle while req_stall is low; each result passes the 30 squaring rounds
// of the log2 unit and the 16 divider steps before it reaches the rsp_ registers
// reset is synchronous: it empties the pipeline and loads the register defaults
// while a result waits under rsp_stall the whole pipeline holds and req_stall is raised

module thermistor_adc_to_celsius_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [tadc_pkg::ADC_BITS-1:0]         req_adc_code,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [15:0]                    rsp_temp_centi_c,
   output logic [1:0]                            rsp_status,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [tadc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire  [tadc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tadc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   // configuration registers
   logic [tadc_pkg::RS_W-1:0]   rs_ff;
   logic [tadc_pkg::COEF_W-1:0] a0_ff;
   logic [tadc_pkg::COEF_W-1:0] a1_ff;
   logic [tadc_pkg::COEF_W-1:0] a3_ff;
   tadc_pkg::reg_index_type     csr_index;
   logic                        csr_write;

   assign csr_index = tadc_pkg::reg_index_type'(csr_paddr[4:3]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff <= tadc_pkg::RS_RESET;
         a0_ff <= tadc_pkg::A0_RESET;
         a1_ff <= tadc_pkg::A1_RESET;
         a3_ff <= tadc_pkg::A3_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tadc_pkg::REG_SERIES_RES: rs_ff <= csr_pwdata[tadc_pkg::RS_W-1:0];
            tadc_pkg::REG_COEF_A0:    a0_ff <= csr_pwdata[tadc_pkg::COEF_W-1:0];
            tadc_pkg::REG_COEF_A1:    a1_ff <= csr_pwdata[tadc_pkg::COEF_W-1:0];
            tadc_pkg::REG_COEF_A3:    a3_ff <= csr_pwdata[tadc_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (csr_index)
         tadc_pkg::REG_SERIES_RES: csr_prdata = tadc_pkg::CSR_DATA_W'(rs_ff);
         tadc_pkg::REG_COEF_A0:    csr_prdata = tadc_pkg::CSR_DATA_W'(a0_ff);
         tadc_pkg::REG_COEF_A1:    csr_prdata = tadc_pkg::CSR_DATA_W'(a1_ff);
         tadc_pkg::REG_COEF_A3:    csr_prdata = tadc_pkg::CSR_DATA_W'(a3_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline advance: everything moves unless a held result blocks it
   logic adv;
   logic rsp_valid_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // control travelling with each word
   tadc_pkg::ctl_type ctl_ff [tadc_pkg::N_STAGES];
   tadc_pkg::ctl_type ctl_in [tadc_pkg::N_STAGES];

   // log2 pipeline
   tadc_pkg::log_stage_type lg_ff [tadc_pkg::LOG_ROUNDS+1];
   tadc_pkg::log_stage_type lg_in [tadc_pkg::LOG_ROUNDS+1];
   tadc_pkg::status_type    pre_in;

   // datapath registers after the log2 unit
   logic [tadc_pkg::MAG_W-1:0]  mag_ff, mag_in;
   tadc_pkg::pp_type            ln_pp_ff, ln_pp_in;
   logic [tadc_pkg::LMAG_W-1:0] lmag_m1_ff, lmag_m1_in;
   tadc_pkg::pp_type            sq_pp_ff, sq_pp_in;
   tadc_pkg::pp_type            t1_pp_ff, t1_pp_in;
   logic [tadc_pkg::LMAG_W-1:0] lmag_q0_ff;
   logic [tadc_pkg::LSQ_W-1:0]  lsq_ff, lsq_in;
   logic [tadc_pkg::SUM_W-1:0]  t1_q1_ff, t1_q1_in;
   logic [tadc_pkg::LMAG_W-1:0] lmag_q1_ff;
   tadc_pkg::pp_type            cub_pp_ff, cub_pp_in;
   logic [tadc_pkg::SUM_W-1:0]  t1_r0_ff;
   logic [tadc_pkg::LCUB_W-1:0] lcub_ff, lcub_in;
   logic [tadc_pkg::SUM_W-1:0]  t1_r1_ff;
   tadc_pkg::pp_type            t3_pp_ff, t3_pp_in;
   logic [tadc_pkg::SUM_W-1:0]  t1_t0_ff;
   logic [tadc_pkg::SUM_W-1:0]  t3_ff, t3_in;
   logic [tadc_pkg::SUM_W-1:0]  t1_t1_ff;
   logic [tadc_pkg::SUM_W-1:0]  sum13_ff, sum13_in;
   logic [tadc_pkg::SUM_W-1:0]  s_ff, s_in;
   logic                        sat_in;
   logic [tadc_pkg::SUM_W-1:0]  num_ff, num_in;
   logic [tadc_pkg::SUM_W-1:0]  s_d0_ff;
   logic                        ovf_in;
   tadc_pkg::div_type           div_ff [tadc_pkg::Q_W];
   tadc_pkg::div_type           div_in [tadc_pkg::Q_W];
   tadc_pkg::div_type           div_start;

   // intermediate sums
   logic [tadc_pkg::LOG_W:0]    lpos, lneg;
   logic                        neg_in;
   logic [tadc_pkg::PROD_W-1:0] ln_sum, sq_sum, t1_sum, cub_sum, t3_sum;
   logic [tadc_pkg::SUM_W-1:0]  a0_ext;
   logic [tadc_pkg::ADC_BITS-1:0] code_rest;

   // entry: probe checks, normalising of the three log2 operands, and the squaring rounds
   always_comb begin
      code_rest = tadc_pkg::ADC_FULL - req_adc_code;
      if (req_adc_code == tadc_pkg::ADC_FULL) begin
         pre_in = tadc_pkg::STAT_OPEN;
      end else if (req_adc_code == '0 || rs_ff == '0) begin
         pre_in = tadc_pkg::STAT_SHORT;
      end else begin
         pre_in = tadc_pkg::STAT_OK;
      end
      lg_in[0].r = tadc_pkg::log_norm(tadc_pkg::M_W'(rs_ff));
      lg_in[0].c = tadc_pkg::log_norm(tadc_pkg::M_W'(req_adc_code));
      lg_in[0].f = tadc_pkg::log_norm(tadc_pkg::M_W'(code_rest));
      for (int i = 1; i <= tadc_pkg::LOG_ROUNDS; i++) begin
         lg_in[i].r = tadc_pkg::log_round(lg_ff[i-1].r);
         lg_in[i].c = tadc_pkg::log_round(lg_ff[i-1].c);
         lg_in[i].f = tadc_pkg::log_round(lg_ff[i-1].f);
      end
   end

   // log ratio, natural log scaling, the powers of L and the a1 and a3 products
   always_comb begin
      lpos = (tadc_pkg::LOG_W+1)'({lg_ff[tadc_pkg::LOG_ROUNDS].r.n,
                                   lg_ff[tadc_pkg::LOG_ROUNDS].r.frac})
           + (tadc_pkg::LOG_W+1)'({lg_ff[tadc_pkg::LOG_ROUNDS].c.n,
                                   lg_ff[tadc_pkg::LOG_ROUNDS].c.frac});
      lneg = (tadc_pkg::LOG_W+1)'({lg_ff[tadc_pkg::LOG_ROUNDS].f.n,
                                   lg_ff[tadc_pkg::LOG_ROUNDS].f.frac});
      neg_in = lneg > lpos;
      mag_in = neg_in ? lneg - lpos : lpos - lneg;

      ln_pp_in = tadc_pkg::pp_mul(tadc_pkg::MUL_W'(mag_ff),
                                  tadc_pkg::MUL_W'(tadc_pkg::LN2_Q28));
      ln_sum = tadc_pkg::pp_sum(ln_pp_ff)
             + (tadc_pkg::PROD_W'(1) << (tadc_pkg::LN2_SH - 1));
      lmag_m1_in = ln_sum[tadc_pkg::LMAG_W+tadc_pkg::LN2_SH-1:tadc_pkg::LN2_SH];

      sq_pp_in = tadc_pkg::pp_mul(tadc_pkg::MUL_W'(lmag_m1_ff),
                                  tadc_pkg::MUL_W'(lmag_m1_ff));
      t1_pp_in = tadc_pkg::pp_mul(a1_ff, tadc_pkg::MUL_W'(lmag_m1_ff));

      sq_sum = tadc_pkg::pp_sum(sq_pp_ff);
      t1_sum = tadc_pkg::pp_sum(t1_pp_ff);
      lsq_in = sq_sum[tadc_pkg::LSQ_W+tadc_pkg::FRAC_BITS-1:tadc_pkg::FRAC_BITS];
      t1_q1_in = t1_sum[tadc_pkg::SUM_W+tadc_pkg::FRAC_BITS-1:tadc_pkg::FRAC_BITS];

      cub_pp_in = tadc_pkg::pp_mul(tadc_pkg::MUL_W'(lsq_ff), tadc_pkg::MUL_W'(lmag_q1_ff));
      cub_sum = tadc_pkg::pp_sum(cub_pp_ff);
      lcub_in = cub_sum[tadc_pkg::LCUB_W+tadc_pkg::FRAC_BITS-1:tadc_pkg::FRAC_BITS];

      t3_pp_in = tadc_pkg::pp_mul(a3_ff, tadc_pkg::MUL_W'(lcub_ff));
      t3_sum = tadc_pkg::pp_sum(t3_pp_ff);
      t3_in = t3_sum[tadc_pkg::SUM_W+tadc_pkg::FRAC_BITS-1:tadc_pkg::FRAC_BITS];
   end

   // denominator with 64-bit wrap, and the zero or negative check
   always_comb begin
      sum13_in = t1_t1_ff + t3_ff;
      a0_ext = tadc_pkg::SUM_W'(a0_ff);
      if (ctl_ff[tadc_pkg::ST_U1].neg) begin
         sat_in = sum13_ff >= a0_ext;
         s_in = a0_ext - sum13_ff;
      end else begin
         s_in = a0_ext + sum13_ff;
         sat_in = s_in == '0;
      end
   end

   // rounded numerator, quotient range check and restoring divider steps
   always_comb begin
      logic [tadc_pkg::DIV_W-1:0] d;
      logic [tadc_pkg::DIV_W-1:0] rem_wide;
      num_in = tadc_pkg::K_NUM + {1'b0, s_ff[tadc_pkg::SUM_W-1:1]};
      ovf_in = {{tadc_pkg::Q_W{1'b0}}, num_ff} >= {s_d0_ff, {tadc_pkg::Q_W{1'b0}}};
      div_start.rem = num_ff;
      div_start.s = s_d0_ff;
      div_start.q = '0;
      for (int j = 0; j < tadc_pkg::Q_W; j++) begin
         div_in[j] = (j == 0) ? div_start : div_ff[(j == 0) ? 0 : j-1];
         d = {{tadc_pkg::Q_W{1'b0}}, div_in[j].s} << (tadc_pkg::Q_W - 1 - j);
         rem_wide = {{tadc_pkg::Q_W{1'b0}}, div_in[j].rem};
         if (rem_wide >= d) begin
            div_in[j].rem = div_in[j].rem - d[tadc_pkg::SUM_W-1:0];
            div_in[j].q[tadc_pkg::Q_W-1-j] = 1'b1;
         end
      end
   end

   // control shifts along, picking up flags where they are found
   always_comb begin
      ctl_in[0].valid = req_valid;
      ctl_in[0].pre = pre_in;
      ctl_in[0].neg = 1'b0;
      ctl_in[0].sat = 1'b0;
      for (int i = 1; i < tadc_pkg::N_STAGES; i++) begin
         ctl_in[i] = ctl_ff[i-1];
      end
      ctl_in[tadc_pkg::ST_C1].neg = neg_in;
      ctl_in[tadc_pkg::ST_U2].sat = sat_in;
      ctl_in[tadc_pkg::ST_D1].sat = ctl_ff[tadc_pkg::ST_D0].sat || ovf_in;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tadc_pkg::N_STAGES; i++) begin
            ctl_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i < tadc_pkg::N_STAGES; i++) begin
            ctl_ff[i] <= ctl_in[i];
         end
         for (int i = 0; i <= tadc_pkg::LOG_ROUNDS; i++) begin
            lg_ff[i] <= lg_in[i];
         end
         mag_ff <= mag_in;
         ln_pp_ff <= ln_pp_in;
         lmag_m1_ff <= lmag_m1_in;
         sq_pp_ff <= sq_pp_in;
         t1_pp_ff <= t1_pp_in;
         lmag_q0_ff <= lmag_m1_ff;
         lsq_ff <= lsq_in;
         t1_q1_ff <= t1_q1_in;
         lmag_q1_ff <= lmag_q0_ff;
         cub_pp_ff <= cub_pp_in;
         t1_r0_ff <= t1_q1_ff;
         lcub_ff <= lcub_in;
         t1_r1_ff <= t1_r0_ff;
         t3_pp_ff <= t3_pp_in;
         t1_t0_ff <= t1_r1_ff;
         t3_ff <= t3_in;
         t1_t1_ff <= t1_t0_ff;
         sum13_ff <= sum13_in;
         s_ff <= s_in;
         num_ff <= num_in;
         s_d0_ff <= s_ff;
         for (int j = 0; j < tadc_pkg::Q_W; j++) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // result formatting into the output register
   tadc_pkg::ctl_type          last_ctl;
   logic [tadc_pkg::Q_W-1:0]   quot;
   logic signed [15:0]         temp_in;
   tadc_pkg::status_type       status_in;
   logic signed [15:0]         rsp_temp_ff;
   tadc_pkg::status_type       rsp_status_ff;

   always_comb begin
      last_ctl = ctl_ff[tadc_pkg::N_STAGES-1];
      quot = div_ff[tadc_pkg::Q_W-1].q;
      if (last_ctl.pre != tadc_pkg::STAT_OK) begin
         temp_in = '0;
         status_in = last_ctl.pre;
      end else if (last_ctl.sat || quot > tadc_pkg::K_MAX) begin
         temp_in = tadc_pkg::TEMP_MAX;
         status_in = tadc_pkg::STAT_SAT;
      end else begin
         temp_in = 16'({1'b0, quot} - tadc_pkg::KELVIN_CENTI);
         status_in = tadc_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last_ctl.valid;
         rsp_temp_ff <= temp_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_temp_centi_c = rsp_temp_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire
